// ===== rtl/static_array_list_engine_macros.svh =====
// Assertion macros shared by the checker files of the list engine.
`ifndef STATIC_ARRAY_LIST_ENGINE_MACROS_SVH
`define STATIC_ARRAY_LIST_ENGINE_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define SALE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication that holds at every clock edge outside reset.
`define SALE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// An implication checked also while reset is asserted.
`define SALE_ASSERT_RESET(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sale_pkg.sv =====
// Types and codes shared by the static array list engine.
`timescale 1ns / 1ps
package sale_pkg;

  // Operation codes.
  localparam logic [3:0] OP_CLEAR     = 4'd0;
  localparam logic [3:0] OP_INS_FIRST = 4'd1;
  localparam logic [3:0] OP_INS_AT    = 4'd2;
  localparam logic [3:0] OP_INS_LAST  = 4'd3;
  localparam logic [3:0] OP_DEL_FIRST = 4'd4;
  localparam logic [3:0] OP_DEL_AT    = 4'd5;
  localparam logic [3:0] OP_DEL_LAST  = 4'd6;
  localparam logic [3:0] OP_SEARCH    = 4'd7;
  localparam logic [3:0] OP_QUERY     = 4'd8;
  localparam logic [3:0] OP_EXTREMES  = 4'd9;
  localparam logic [3:0] OP_SORT      = 4'd10;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_POS   = 2'd3;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_SHR,
    S_SHW,
    S_DV,
    S_SLR,
    S_SLW,
    S_SR,
    S_SC,
    S_XR,
    S_XC,
    S_OA,
    S_OB,
    S_OR,
    S_OC,
    S_DONE
  } state_t;

  // Result of the shared compare unit.
  typedef struct packed {
    logic eq;
    logic gt;
    logic lt;
  } cmp_t;

endpackage

// ===== rtl/sale_cmp.sv =====
// Signed compare unit shared by search, extremes and sort.
`timescale 1ns / 1ps
module sale_cmp #(
  parameter int W = 16
) (
  input  logic [W-1:0]    a,
  input  logic [W-1:0]    b,
  output sale_pkg::cmp_t  res
);

  // One signed two's complement compare of a against b.
  always_comb begin
    res.eq = (a == b);
    res.gt = ($signed(a) > $signed(b));
    res.lt = ($signed(a) < $signed(b));
  end

endmodule

// ===== rtl/static_array_list_engine.sv =====
// Top level of the static array list engine: sequencer, element memory and result register.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | op, value, position, descending
//   out_    | output    | out_valid/out_stall| status, value_out, min_out, found_index,
//           |           |                    | found, length, is_empty, is_full
//
// The element memory has one write and one registered read port; each element
// visited takes a read state and then a write or compare state. Insert, delete, search
// and extremes walk the list at most once; sort makes bubble passes, each one shorter.
// Clear, query and failed operations go straight from the start state to done.
// Reset empties the list at once; the memory is not cleared.
// A new transaction is taken only in idle; a waiting result holds the next one in its last step.
`timescale 1ns / 1ps
module static_array_list_engine #(
  parameter int CAPACITY_MAX  = 64,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_op,
  input  logic [15:0] in_value,
  input  logic [5:0]  in_position,
  input  logic        in_descending,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_value_out,
  output logic [15:0] out_min_out,
  output logic [5:0]  out_found_index,
  output logic        out_found,
  output logic [6:0]  out_length,
  output logic        out_is_empty,
  output logic        out_is_full
);

  localparam int CW = $clog2(CAPACITY_MAX + 1);
  localparam int AW = $clog2(CAPACITY_MAX);
  localparam int PW = CW + 6;
  localparam int EW = ELEMENT_WIDTH;

  sale_pkg::state_t state_r, state_nxt;

  logic [3:0]    op_r, op_nxt;
  logic [EW-1:0] elem_r, elem_nxt;
  logic [5:0]    pos_r, pos_nxt;
  logic          desc_r, desc_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] end_r, end_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [EW-1:0] cur_r, cur_nxt;
  logic [EW-1:0] mx_r, mx_nxt;
  logic [EW-1:0] mn_r, mn_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [15:0]   vout_r, vout_nxt;
  logic [15:0]   mout_r, mout_nxt;
  logic [5:0]    fidx_r, fidx_nxt;
  logic          fnd_r, fnd_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_load;

  logic [EW-1:0] mem [CAPACITY_MAX];
  logic [EW-1:0] rdata_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  logic [PW-1:0] p_wide;
  logic [PW-1:0] count_wide;
  logic [EW-1:0] cmp_b;
  sale_pkg::cmp_t cmp0, cmp1;

  // Shared compare units: memory data against a working operand and the minimum.
  sale_cmp #(.W(EW)) u_cmp0 (.a(rdata_r), .b(cmp_b), .res(cmp0));
  sale_cmp #(.W(EW)) u_cmp1 (.a(rdata_r), .b(mn_r),  .res(cmp1));

  always_comb begin
    case (state_r)
      sale_pkg::S_SC:              cmp_b = elem_r;
      sale_pkg::S_XC:              cmp_b = mx_r;
      default:                     cmp_b = cur_r;
    endcase
  end

  // Target position of an insert or delete, widened for the range check.
  always_comb begin
    count_wide = PW'(count_r);
    case (op_r)
      sale_pkg::OP_INS_FIRST, sale_pkg::OP_DEL_FIRST: p_wide = '0;
      sale_pkg::OP_INS_LAST:                          p_wide = count_wide;
      sale_pkg::OP_DEL_LAST:                          p_wide = count_wide - PW'(1);
      default:                                        p_wide = PW'(pos_r);
    endcase
  end

  // Element memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sale_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    elem_r <= elem_nxt;
    pos_r  <= pos_nxt;
    desc_r <= desc_nxt;
    p_r    <= p_nxt;
    idx_r  <= idx_nxt;
    end_r  <= end_nxt;
    cur_r  <= cur_nxt;
    mx_r   <= mx_nxt;
    mn_r   <= mn_nxt;
    st_r   <= st_nxt;
    vout_r <= vout_nxt;
    mout_r <= mout_nxt;
    fidx_r <= fidx_nxt;
    fnd_r  <= fnd_nxt;
  end

  // Result register, loaded when the sequencer finishes.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status      <= st_r;
      out_value_out   <= vout_r;
      out_min_out     <= mout_r;
      out_found_index <= fidx_r;
      out_found       <= fnd_r;
      out_length      <= 7'(count_r);
      out_is_empty    <= (count_r == '0);
      out_is_full     <= (count_r == CW'(CAPACITY_MAX));
    end
  end

  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != sale_pkg::S_IDLE);

  // Sequencer: next state, memory access and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    elem_nxt      = elem_r;
    pos_nxt       = pos_r;
    desc_nxt      = desc_r;
    p_nxt         = p_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    mx_nxt        = mx_r;
    mn_nxt        = mn_r;
    st_nxt        = st_r;
    vout_nxt      = vout_r;
    mout_nxt      = mout_r;
    fidx_nxt      = fidx_r;
    fnd_nxt       = fnd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_load      = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    wr_addr       = idx_r[AW-1:0];
    wr_data       = rdata_r;
    wr_en         = 1'b0;

    unique case (state_r)
      sale_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          elem_nxt  = EW'($signed(in_value));
          pos_nxt   = in_position;
          desc_nxt  = in_descending;
          st_nxt    = sale_pkg::ST_OK;
          vout_nxt  = '0;
          mout_nxt  = '0;
          fidx_nxt  = '0;
          fnd_nxt   = 1'b0;
          state_nxt = sale_pkg::S_START;
        end
      end

      sale_pkg::S_START: begin
        state_nxt = sale_pkg::S_DONE;
        idx_nxt   = '0;
        case (op_r)
          sale_pkg::OP_CLEAR: begin
            count_nxt = '0;
          end
          sale_pkg::OP_INS_FIRST, sale_pkg::OP_INS_AT, sale_pkg::OP_INS_LAST: begin
            if (count_r == CW'(CAPACITY_MAX)) begin
              st_nxt = sale_pkg::ST_FULL;
            end else if (p_wide > count_wide) begin
              st_nxt = sale_pkg::ST_POS;
            end else begin
              p_nxt     = CW'(p_wide);
              idx_nxt   = count_r;
              state_nxt = sale_pkg::S_SHR;
            end
          end
          sale_pkg::OP_DEL_FIRST, sale_pkg::OP_DEL_AT, sale_pkg::OP_DEL_LAST: begin
            if (count_r == '0) begin
              st_nxt = sale_pkg::ST_EMPTY;
            end else if (p_wide >= count_wide) begin
              st_nxt = sale_pkg::ST_POS;
            end else begin
              rd_addr   = AW'(p_wide);
              idx_nxt   = CW'(p_wide);
              state_nxt = sale_pkg::S_DV;
            end
          end
          sale_pkg::OP_SEARCH: begin
            state_nxt = sale_pkg::S_SR;
          end
          sale_pkg::OP_EXTREMES: begin
            if (count_r == '0) begin
              st_nxt = sale_pkg::ST_EMPTY;
            end else begin
              state_nxt = sale_pkg::S_XR;
            end
          end
          sale_pkg::OP_SORT: begin
            if (count_r > CW'(1)) begin
              end_nxt   = count_r - CW'(1);
              state_nxt = sale_pkg::S_OA;
            end
          end
          default: begin
          end
        endcase
      end

      // Insert: move elements up one place from the back, then write the new one.
      sale_pkg::S_SHR: begin
        if (idx_r == p_r) begin
          wr_en     = 1'b1;
          wr_data   = elem_r;
          count_nxt = count_r + CW'(1);
          state_nxt = sale_pkg::S_DONE;
        end else begin
          rd_addr   = AW'(idx_r - CW'(1));
          state_nxt = sale_pkg::S_SHW;
        end
      end

      sale_pkg::S_SHW: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = sale_pkg::S_SHR;
      end

      // Delete: capture the removed element, then close the gap.
      sale_pkg::S_DV: begin
        vout_nxt  = 16'(rdata_r);
        state_nxt = sale_pkg::S_SLR;
      end

      sale_pkg::S_SLR: begin
        if ((idx_r + CW'(1)) >= count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = sale_pkg::S_DONE;
        end else begin
          rd_addr   = AW'(idx_r + CW'(1));
          state_nxt = sale_pkg::S_SLW;
        end
      end

      sale_pkg::S_SLW: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_r + CW'(1);
        state_nxt = sale_pkg::S_SLR;
      end

      // Search: walk from the front until the first match.
      sale_pkg::S_SR: begin
        if (idx_r >= count_r) begin
          state_nxt = sale_pkg::S_DONE;
        end else begin
          state_nxt = sale_pkg::S_SC;
        end
      end

      sale_pkg::S_SC: begin
        if (cmp0.eq) begin
          fnd_nxt   = 1'b1;
          fidx_nxt  = 6'(idx_r);
          state_nxt = sale_pkg::S_DONE;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = sale_pkg::S_SR;
        end
      end

      // Extremes: one walk tracking both maximum and minimum.
      sale_pkg::S_XR: begin
        if (idx_r >= count_r) begin
          vout_nxt  = 16'(mx_r);
          mout_nxt  = 16'(mn_r);
          state_nxt = sale_pkg::S_DONE;
        end else begin
          state_nxt = sale_pkg::S_XC;
        end
      end

      sale_pkg::S_XC: begin
        if (idx_r == '0 || cmp0.gt) begin
          mx_nxt = rdata_r;
        end
        if (idx_r == '0 || cmp1.lt) begin
          mn_nxt = rdata_r;
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = sale_pkg::S_XR;
      end

      // Sort: bubble passes carrying the element that belongs farthest back.
      sale_pkg::S_OA: begin
        rd_addr   = '0;
        state_nxt = sale_pkg::S_OB;
      end

      sale_pkg::S_OB: begin
        cur_nxt   = rdata_r;
        idx_nxt   = '0;
        state_nxt = sale_pkg::S_OR;
      end

      sale_pkg::S_OR: begin
        if (idx_r == end_r) begin
          wr_en   = 1'b1;
          wr_data = cur_r;
          if (end_r == CW'(1)) begin
            state_nxt = sale_pkg::S_DONE;
          end else begin
            end_nxt   = end_r - CW'(1);
            state_nxt = sale_pkg::S_OA;
          end
        end else begin
          rd_addr   = AW'(idx_r + CW'(1));
          state_nxt = sale_pkg::S_OC;
        end
      end

      sale_pkg::S_OC: begin
        wr_en = 1'b1;
        if (desc_r ? cmp0.gt : cmp0.lt) begin
          wr_data = rdata_r;
        end else begin
          wr_data = cur_r;
          cur_nxt = rdata_r;
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = sale_pkg::S_OR;
      end

      sale_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sale_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = sale_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sale_chk.sv =====
// Port checker for the static array list engine, bound to the top level.
`timescale 1ns / 1ps
`include "static_array_list_engine_macros.svh"
module sale_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [5:0]  out_found_index,
  input logic        out_found,
  input logic [6:0]  out_length,
  input logic        out_is_empty,
  input logic        out_is_full
);

  // A stalled result stays offered.
  `SALE_ASSERT_IMPL(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
  // The empty flag agrees with the reported length.
  `SALE_ASSERT_ALWAYS(a_empty_len, clk, rst_n, !out_valid || (out_is_empty == (out_length == 7'd0)), "empty flag disagrees with length")
  // A miss reports index zero.
  `SALE_ASSERT_ALWAYS(a_found_idx, clk, rst_n, !out_valid || out_found || (out_found_index == 6'd0), "index set without a match")
  // The engine is busy right after taking a transaction.
  `SALE_ASSERT_IMPL(a_busy, clk, rst_n, in_valid && !in_stall, in_stall, "engine idle after taking a transaction")
  // Reset leaves no result on offer.
  `SALE_ASSERT_RESET(a_reset, clk, !rst_n, !out_valid, "result offered after reset")

endmodule

bind static_array_list_engine sale_chk u_sale_chk (.*);

// ===== bench/list_checker.sv =====
// Checker for the list engine: predicts each result and compares it with the block's output.
`timescale 1ns / 1ps
module list_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  in_op,
  input  logic [15:0] in_value,
  input  logic [5:0]  in_position,
  input  logic        in_descending,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_value_out,
  input  logic [15:0] out_min_out,
  input  logic [5:0]  out_found_index,
  input  logic        out_found,
  input  logic [6:0]  out_length,
  input  logic        out_is_empty,
  input  logic        out_is_full,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  localparam int CAP = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] value_out;
    logic [15:0] min_out;
    logic [5:0]  found_index;
    logic        found;
    logic [6:0]  length;
    logic        is_empty;
    logic        is_full;
  } list_result_t;

  logic signed [15:0] shadow_list [CAP];
  int unsigned        shadow_len;
  list_result_t       expected_results [$];

  // Apply one operation to the shadow list and return what the block should report.
  function automatic list_result_t apply_list_op(logic [3:0] op, logic signed [15:0] val,
                                                 logic [5:0] pos, logic desc);
    list_result_t r;
    int unsigned p;
    logic signed [15:0] mx, mn, tmp;
    int j;
    r = '0;
    r.status = sale_pkg::ST_OK;
    case (op)
      sale_pkg::OP_CLEAR: shadow_len = 0;
      sale_pkg::OP_INS_FIRST, sale_pkg::OP_INS_AT, sale_pkg::OP_INS_LAST: begin
        if (shadow_len >= CAP) begin
          r.status = sale_pkg::ST_FULL;
        end else begin
          p = (op == sale_pkg::OP_INS_FIRST) ? 0 :
              (op == sale_pkg::OP_INS_LAST) ? shadow_len : pos;
          if (p > shadow_len) begin
            r.status = sale_pkg::ST_POS;
          end else begin
            for (int i = shadow_len; i > p; i--) shadow_list[i] = shadow_list[i-1];
            shadow_list[p] = val;
            shadow_len++;
          end
        end
      end
      sale_pkg::OP_DEL_FIRST, sale_pkg::OP_DEL_AT, sale_pkg::OP_DEL_LAST: begin
        if (shadow_len == 0) begin
          r.status = sale_pkg::ST_EMPTY;
        end else begin
          p = (op == sale_pkg::OP_DEL_FIRST) ? 0 :
              (op == sale_pkg::OP_DEL_LAST) ? shadow_len - 1 : pos;
          if (p >= shadow_len) begin
            r.status = sale_pkg::ST_POS;
          end else begin
            r.value_out = shadow_list[p];
            for (int i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
            shadow_len--;
          end
        end
      end
      sale_pkg::OP_SEARCH: begin
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_list[i] == val && !r.found) begin
            r.found = 1'b1;
            r.found_index = i[5:0];
          end
        end
      end
      sale_pkg::OP_EXTREMES: begin
        if (shadow_len == 0) begin
          r.status = sale_pkg::ST_EMPTY;
        end else begin
          mx = shadow_list[0];
          mn = shadow_list[0];
          for (int i = 1; i < shadow_len; i++) begin
            if (shadow_list[i] > mx) mx = shadow_list[i];
            if (shadow_list[i] < mn) mn = shadow_list[i];
          end
          r.value_out = mx;
          r.min_out = mn;
        end
      end
      sale_pkg::OP_SORT: begin
        // Insertion sort over the stored elements only.
        for (int i = 1; i < shadow_len; i++) begin
          tmp = shadow_list[i];
          j = i;
          while (j > 0 && (desc ? (shadow_list[j-1] < tmp) : (shadow_list[j-1] > tmp))) begin
            shadow_list[j] = shadow_list[j-1];
            j--;
          end
          shadow_list[j] = tmp;
        end
      end
      default: ;
    endcase
    r.length = shadow_len[6:0];
    r.is_empty = (shadow_len == 0);
    r.is_full = (shadow_len >= CAP);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch on result %0d: %s got %0h expected %0h", result_count, what, got, want);
    fail_count++;
  endtask

  assign pending_count = expected_results.size();

  // Predict on every input transaction and check every output transaction.
  always @(posedge clk) begin
    list_result_t w;
    if (!rst_n) begin
      shadow_len = 0;
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(apply_list_op(in_op, in_value, in_position, in_descending));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result transaction %0d", result_count);
          fail_count++;
        end else begin
          w = expected_results.pop_front();
          if (out_status != w.status) report_mismatch("status", out_status, w.status);
          if (out_value_out != w.value_out) report_mismatch("value_out", out_value_out, w.value_out);
          if (out_min_out != w.min_out) report_mismatch("min_out", out_min_out, w.min_out);
          if (out_found_index != w.found_index)
            report_mismatch("found_index", out_found_index, w.found_index);
          if (out_found != w.found) report_mismatch("found", out_found, w.found);
          if (out_length != w.length) report_mismatch("length", out_length, w.length);
          if (out_is_empty != w.is_empty) report_mismatch("is_empty", out_is_empty, w.is_empty);
          if (out_is_full != w.is_full) report_mismatch("is_full", out_is_full, w.is_full);
        end
        result_count++;
      end
    end
  end
endmodule

// ===== bench/testbench.sv =====
// Top of the list engine bench: clock, reset, stimulus with idling phases, and the verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int MAX_CYCLES = 20000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_op = '0;
  logic [15:0] in_value = '0;
  logic [5:0] in_position = '0;
  logic in_descending = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [15:0] out_value_out, out_min_out;
  logic [5:0] out_found_index;
  logic out_found;
  logic [6:0] out_length;
  logic out_is_empty, out_is_full;
  int fail_count, pending_count, result_count;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int hold_cycles = 0;
  int sent_count = 0;
  int fill_mode = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  static_array_list_engine i_dut (.*);

  list_checker i_checker (.*);

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long counted hold-off when asked.
  always @(negedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
      hold_cycles++;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one transaction and wait for it to be taken; valid stays up for the next one.
  task automatic send_item(logic [3:0] op, logic [15:0] val, logic [5:0] pos, logic desc);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_value <= val;
    in_position <= pos;
    in_descending <= desc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  // Random value drawn from a small pool now and then, so searches hit.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(3))
      0: return 16'(16'h8000 + $urandom_range(3));
      1: return 16'(16'h7FFC + $urandom_range(3));
      2: return 16'($urandom_range(7));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_item();
    logic [3:0] op;
    int r;
    r = $urandom_range(99);
    if (r < 3) op = 4'($urandom_range(15, 11));
    else if (r < 5) op = sale_pkg::OP_CLEAR;
    else if (fill_mode == 1 && r < 60)
      op = 4'($urandom_range(sale_pkg::OP_INS_LAST, sale_pkg::OP_INS_FIRST));
    else if (fill_mode == 2 && r < 60)
      op = 4'($urandom_range(sale_pkg::OP_DEL_LAST, sale_pkg::OP_DEL_FIRST));
    else if (r < 85)
      op = 4'($urandom_range(sale_pkg::OP_EXTREMES, sale_pkg::OP_INS_FIRST));
    else op = ($urandom_range(9) == 0) ? sale_pkg::OP_SORT : sale_pkg::OP_SEARCH;
    send_item(op, pick_value(), 6'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty-list cases, extremes of values and positions, full list.
    send_item(sale_pkg::OP_DEL_FIRST, 16'h0000, 6'd0, 1'b0);
    send_item(sale_pkg::OP_DEL_AT, 16'h0000, 6'd0, 1'b0);
    send_item(sale_pkg::OP_EXTREMES, 16'h0000, 6'd0, 1'b0);
    send_item(sale_pkg::OP_SEARCH, 16'h0005, 6'd0, 1'b0);
    send_item(sale_pkg::OP_SORT, 16'h0000, 6'd0, 1'b1);
    send_item(sale_pkg::OP_INS_LAST, 16'h7FFF, 6'd0, 1'b0);
    send_item(sale_pkg::OP_SORT, 16'h0000, 6'd0, 1'b0);
    send_item(sale_pkg::OP_INS_AT, 16'h1234, 6'd2, 1'b0);
    send_item(sale_pkg::OP_INS_AT, 16'h8000, 6'd1, 1'b0);
    send_item(sale_pkg::OP_INS_FIRST, 16'hFFFF, 6'd0, 1'b0);
    send_item(sale_pkg::OP_DEL_AT, 16'h0000, 6'd63, 1'b0);
    send_item(sale_pkg::OP_SEARCH, 16'h8000, 6'd0, 1'b0);
    send_item(sale_pkg::OP_EXTREMES, 16'h0000, 6'd0, 1'b0);
    send_item(sale_pkg::OP_SORT, 16'h0000, 6'd0, 1'b1);
    send_item(sale_pkg::OP_SORT, 16'h0000, 6'd0, 1'b0);
    send_item(sale_pkg::OP_QUERY, 16'h0000, 6'd0, 1'b0);
    send_item(4'd15, 16'hFFFF, 6'd63, 1'b1);
    send_item(sale_pkg::OP_DEL_LAST, 16'h0000, 6'd0, 1'b0);
    send_item(sale_pkg::OP_CLEAR, 16'h0000, 6'd0, 1'b0);
    for (int i = 0; i < 64; i++) send_item(sale_pkg::OP_INS_FIRST, 16'($urandom), 6'd0, 1'b0);
    send_item(sale_pkg::OP_INS_LAST, 16'h0001, 6'd0, 1'b0);
    send_item(sale_pkg::OP_INS_AT, 16'h0001, 6'd63, 1'b0);
    send_item(sale_pkg::OP_DEL_AT, 16'h0000, 6'd63, 1'b0);
    send_item(sale_pkg::OP_INS_AT, 16'h0002, 6'd63, 1'b0);
    send_item(sale_pkg::OP_EXTREMES, 16'h0000, 6'd0, 1'b0);
    send_item(sale_pkg::OP_CLEAR, 16'h0000, 6'd0, 1'b0);

    // Long receiver hold-off while the sender keeps offering.
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 8; i++) send_item(sale_pkg::OP_INS_LAST, 16'($urandom), 6'd0, 1'b0);
        in_valid <= 1'b0;
      end
      begin
        while (hold_cycles < 400) @(negedge clk);
        hold_off = 1'b0;
      end
    join
    wait_drained();

    // Random phases with different idling on each side.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin sender_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      fill_mode = ph % 3;
      for (int i = 0; i < 64; i++) random_item();
      in_valid <= 1'b0;
      wait_drained();
    end

    $display("Ran %0d transactions, %0d results, covering every operation,", sent_count,
             result_count);
    $display("full and empty lists, bad positions, and idling on both channels.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
